FILE: rtl/aac_pkg.sv
// Shared widths, defaults and request codes for the address-resolution cache.
package aac_pkg;

  // Table depth default
  localparam int NUM_ENTRIES_DEF = 8;

  // Field widths
  localparam int IP_W   = 32;
  localparam int MAC_W  = 48;
  localparam int SLOT_W = 3;

  // Packed stream widths; the tdata widths are rounded up to whole bytes
  localparam int IN_TDATA_W  = ((IP_W + MAC_W + 7) / 8) * 8;
  localparam int OUT_RAW_W   = 1 + MAC_W + SLOT_W + 1 + 1;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Request kinds carried on in_tuser
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

endpackage : aac_pkg

FILE: rtl/arp_address_cache_core.sv
// Sequence: a request with address 0 goes straight from ST_IDLE to ST_DONE and is flagged ignored;
// any other request walks the table one entry a cycle in ST_SCAN, stopping at the first matching
// entry or at the last entry, then passes through ST_RES and ST_DONE into the output register.
// One request at a time: in_tready is high only between requests, and a held result stalls input.
// Reset (rst_n low, synchronous) clears the entry valid bits, so every entry reads as free.
module arp_address_cache_core
  import aac_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // ip_addr[31:0], mac_in[79:32]
  input  logic                   in_tuser,   // req_type
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // hit[0], mac_out[48:1], slot[51:49],
                                             // evicted[52], ignored[53], zero pad above
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RES,
    ST_DONE
  } state_t;

  state_t state_r;

  // Latched request
  logic             req_r;
  logic [IP_W-1:0]  ip_r;
  logic [MAC_W-1:0] mac_r;

  // Walk control
  logic [CNT_W-1:0] cnt_r;
  logic             chk_v_r;
  logic [IDX_W-1:0] chk_idx_r;
  logic             match_r;
  logic [IDX_W-1:0] match_idx_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;

  // Tables: keys and hardware addresses in memories, valid bits in flops
  logic [IP_W-1:0]        key_mem [NUM_ENTRIES];
  logic [MAC_W-1:0]       mac_mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_r;
  logic [IP_W-1:0]        key_rd_r;
  logic                   vld_rd_r;
  logic [MAC_W-1:0]       mac_rd_r;

  // Pending result
  logic              res_hit_r;
  logic              res_mac_sel_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic              res_evict_r;
  logic              res_ign_r;

  // Output register
  logic              out_tvalid_r;
  logic              out_hit_r;
  logic [MAC_W-1:0]  out_mac_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_evict_r;
  logic              out_ign_r;

  logic             in_acc;
  logic             issue;
  logic             cmp_eq;
  logic             last_chk;
  logic             scan_end;
  logic             out_load;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;
  logic             mem_we;
  logic             mac_re;
  logic             is_upd;

  // Sequencer decode and the shared key comparator
  always_comb begin
    in_acc   = in_tvalid && in_tready;
    is_upd   = (req_r == REQ_UPDATE);
    issue    = (state_r == ST_SCAN) && (cnt_r < CNT_W'(NUM_ENTRIES));
    rd_idx   = cnt_r[IDX_W-1:0];
    cmp_eq   = chk_v_r && vld_rd_r && (key_rd_r == ip_r);
    last_chk = (chk_idx_r == IDX_W'(NUM_ENTRIES - 1));
    scan_end = chk_v_r && (cmp_eq || last_chk);
    out_load = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);
    if (match_r) begin
      wr_idx = match_idx_r;
    end else if (free_r) begin
      wr_idx = free_idx_r;
    end else begin
      wr_idx = '0;
    end
    mem_we = (state_r == ST_RES) && is_upd;
    mac_re = (state_r == ST_RES) && !is_upd && match_r;
  end

  // Table memories, registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_idx] <= ip_r;
      mac_mem[wr_idx] <= mac_r;
    end
    if (issue) begin
      key_rd_r <= key_mem[rd_idx];
    end
    if (mac_re) begin
      mac_rd_r <= mac_mem[match_idx_r];
    end
  end

  // Sequencer, valid bits and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
      chk_v_r      <= 1'b0;
      match_r      <= 1'b0;
      free_r       <= 1'b0;
      cnt_r        <= '0;
    end else begin
      // result valid: set on load, cleared once taken
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (mem_we) begin
        valid_r[wr_idx] <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            req_r   <= in_tuser;
            ip_r    <= in_tdata[IP_W-1:0];
            mac_r   <= in_tdata[IP_W+MAC_W-1:IP_W];
            cnt_r   <= '0;
            chk_v_r <= 1'b0;
            match_r <= 1'b0;
            free_r  <= 1'b0;
            if (in_tdata[IP_W-1:0] == '0) begin
              // reserved address: nothing to do
              res_hit_r     <= 1'b0;
              res_mac_sel_r <= 1'b0;
              res_slot_r    <= '0;
              res_evict_r   <= 1'b0;
              res_ign_r     <= 1'b1;
              state_r       <= ST_DONE;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // issue next read, compare the entry read last cycle
          if (issue) begin
            cnt_r    <= cnt_r + CNT_W'(1);
            vld_rd_r <= valid_r[rd_idx];
          end
          chk_v_r   <= issue && !scan_end;
          chk_idx_r <= rd_idx;
          if (chk_v_r) begin
            if (cmp_eq) begin
              match_r     <= 1'b1;
              match_idx_r <= chk_idx_r;
              state_r     <= ST_RES;
            end else begin
              if (!vld_rd_r && !free_r) begin
                free_r     <= 1'b1;
                free_idx_r <= chk_idx_r;
              end
              if (last_chk) begin
                state_r <= ST_RES;
              end
            end
          end
        end
        ST_RES: begin
          res_hit_r     <= match_r;
          res_mac_sel_r <= !is_upd && match_r;
          res_ign_r     <= 1'b0;
          res_evict_r   <= is_upd && !match_r && !free_r;
          if (match_r || is_upd) begin
            res_slot_r <= SLOT_W'(wr_idx);
          end else begin
            res_slot_r <= '0;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_hit_r    <= res_hit_r;
            out_mac_r    <= res_mac_sel_r ? mac_rd_r : '0;
            out_slot_r   <= res_slot_r;
            out_evict_r  <= res_evict_r;
            out_ign_r    <= res_ign_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Ports
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_RAW_W)'(0), out_ign_r, out_evict_r, out_slot_r,
                       out_mac_r, out_hit_r};

endmodule : arp_address_cache_core
